// ===== design/dl_pkg.sv =====
// Shared types, token codes and keyword tables for the Datalog lexer.
package dl_pkg;

  localparam int LINE_WIDTH_DEF   = 16;
  localparam int LENGTH_WIDTH_DEF = 12;
  localparam int KIND_WIDTH       = 5;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

  // Token kinds.
  localparam logic [KIND_WIDTH-1:0] K_COMMA     = 5'd0;
  localparam logic [KIND_WIDTH-1:0] K_PERIOD    = 5'd1;
  localparam logic [KIND_WIDTH-1:0] K_QMARK     = 5'd2;
  localparam logic [KIND_WIDTH-1:0] K_LPAREN    = 5'd3;
  localparam logic [KIND_WIDTH-1:0] K_RPAREN    = 5'd4;
  localparam logic [KIND_WIDTH-1:0] K_COLON     = 5'd5;
  localparam logic [KIND_WIDTH-1:0] K_COLONDASH = 5'd6;
  localparam logic [KIND_WIDTH-1:0] K_MUL       = 5'd7;
  localparam logic [KIND_WIDTH-1:0] K_ADD       = 5'd8;
  localparam logic [KIND_WIDTH-1:0] K_KW0       = 5'd9;
  localparam logic [KIND_WIDTH-1:0] K_ID        = 5'd13;
  localparam logic [KIND_WIDTH-1:0] K_STRING    = 5'd14;
  localparam logic [KIND_WIDTH-1:0] K_COMMENT   = 5'd15;
  localparam logic [KIND_WIDTH-1:0] K_UNDEF     = 5'd16;
  localparam logic [KIND_WIDTH-1:0] K_EOF       = 5'd17;

  // Byte categories produced by the front end.
  localparam logic [3:0] C_PUNCT   = 4'd0;
  localparam logic [3:0] C_COLON   = 4'd1;
  localparam logic [3:0] C_QUOTE   = 4'd2;
  localparam logic [3:0] C_HASH    = 4'd3;
  localparam logic [3:0] C_NEWLINE = 4'd4;
  localparam logic [3:0] C_SPACE   = 4'd5;
  localparam logic [3:0] C_ALPHA   = 4'd6;
  localparam logic [3:0] C_DIGIT   = 4'd7;
  localparam logic [3:0] C_OTHER   = 4'd8;

  // Scanner modes.
  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_COLON    = 4'd1;
  localparam logic [3:0] M_ID       = 4'd2;
  localparam logic [3:0] M_STR      = 4'd3;
  localparam logic [3:0] M_STRQ     = 4'd4;
  localparam logic [3:0] M_HASH     = 4'd5;
  localparam logic [3:0] M_LINE     = 4'd6;
  localparam logic [3:0] M_BLOCK    = 4'd7;
  localparam logic [3:0] M_BLOCKBAR = 4'd8;

  typedef struct packed {
    logic                  eoi;
    logic [7:0]            ch;
    logic [3:0]            cat;
    logic [KIND_WIDTH-1:0] punct;
    logic                  dash;
    logic                  bar;
  } item_t;

  // Keyword text, first character in the top byte, shorter words padded at the end.
  localparam logic [3:0][55:0] KW_TEXT = {"Queries", {"Rules", 16'h0000},
                                          {"Facts", 16'h0000}, "Schemes"};
  localparam logic [3:0][2:0]  KW_LEN  = {3'd7, 3'd5, 3'd5, 3'd7};

  // Drops every keyword that does not have ch at position pos.
  function automatic logic [3:0] kw_narrow(input logic [3:0] cands, input logic [7:0] ch,
                                           input logic in_range, input logic [2:0] pos);
    logic [3:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      if (cands[k] && in_range && (pos < KW_LEN[k])) begin
        r[k] = (KW_TEXT[k][(55 - 8 * int'(pos)) -: 8] == ch);
      end
    end
    return r;
  endfunction

endpackage

// ===== design/dl_front.sv =====
// Front end: input handshake and byte classification into queue items.
module dl_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_end_of_input,
  input  logic          q_full,
  output logic          q_push,
  output dl_pkg::item_t q_item
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.eoi   = in_end_of_input;
    q_item.ch    = in_byte;
    q_item.dash  = (in_byte == "-");
    q_item.bar   = (in_byte == "|");
    q_item.punct = dl_pkg::K_COMMA;
    q_item.cat   = dl_pkg::C_OTHER;
    unique case (in_byte) inside
      ",": begin
        q_item.cat = dl_pkg::C_PUNCT;
      end
      ".": begin
        q_item.cat   = dl_pkg::C_PUNCT;
        q_item.punct = dl_pkg::K_PERIOD;
      end
      "?": begin
        q_item.cat   = dl_pkg::C_PUNCT;
        q_item.punct = dl_pkg::K_QMARK;
      end
      "(": begin
        q_item.cat   = dl_pkg::C_PUNCT;
        q_item.punct = dl_pkg::K_LPAREN;
      end
      ")": begin
        q_item.cat   = dl_pkg::C_PUNCT;
        q_item.punct = dl_pkg::K_RPAREN;
      end
      "*": begin
        q_item.cat   = dl_pkg::C_PUNCT;
        q_item.punct = dl_pkg::K_MUL;
      end
      "+": begin
        q_item.cat   = dl_pkg::C_PUNCT;
        q_item.punct = dl_pkg::K_ADD;
      end
      ":":     q_item.cat = dl_pkg::C_COLON;
      8'h27:   q_item.cat = dl_pkg::C_QUOTE;
      "#":     q_item.cat = dl_pkg::C_HASH;
      8'h0A:   q_item.cat = dl_pkg::C_NEWLINE;
      8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: q_item.cat = dl_pkg::C_SPACE;
      [8'h41:8'h5A], [8'h61:8'h7A]:      q_item.cat = dl_pkg::C_ALPHA;
      [8'h30:8'h39]:                     q_item.cat = dl_pkg::C_DIGIT;
      default: q_item.cat = dl_pkg::C_OTHER;
    endcase
  end

endmodule

// ===== design/dl_fifo.sv =====
// Short queue of classified items between the front end and the scanner.
module dl_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dl_pkg::item_t wr_item,
  output logic          full,
  input  logic          pop,
  output dl_pkg::item_t rd_item,
  output logic          not_empty
);

  dl_pkg::item_t                mem_r [dl_pkg::QUEUE_DEPTH];
  logic [dl_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [dl_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [dl_pkg::QPTR_W:0]      count_r, count_nxt;

  assign full      = (count_r == (dl_pkg::QPTR_W + 1)'(dl_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (dl_pkg::QPTR_W + 1)'(dl_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule

// ===== design/dl_back.sv =====
// Back end: scanner state, token generation and the output register.
module dl_back #(
  parameter int LINE_WIDTH   = dl_pkg::LINE_WIDTH_DEF,
  parameter int LENGTH_WIDTH = dl_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dl_pkg::item_t                 item,
  input  logic                          item_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dl_pkg::KIND_WIDTH-1:0] out_token_kind,
  output logic [LINE_WIDTH-1:0]         out_token_line,
  output logic [LENGTH_WIDTH-1:0]       out_token_length,
  output logic                          out_last_of_run
);

  localparam int KW = dl_pkg::KIND_WIDTH;
  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;
  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;
  localparam logic [LENGTH_WIDTH-1:0] LEN_ONE  = LENGTH_WIDTH'(1);
  localparam logic [LENGTH_WIDTH-1:0] LEN_TWO  = LENGTH_WIDTH'(2);
  localparam logic [LENGTH_WIDTH-1:0] LEN_KW   = LENGTH_WIDTH'(7);

  logic [3:0]              mode_r, mode_nxt;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt;
  logic [LINE_WIDTH-1:0]   start_r, start_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic [3:0]              cand_r, cand_nxt;
  logic                    ended_r, ended_nxt;
  logic                    phase_r, phase_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [KW-1:0]           out_kind_r, out_kind_nxt;
  logic [LINE_WIDTH-1:0]   out_line_r, out_line_nxt;
  logic [LENGTH_WIDTH-1:0] out_len_r, out_len_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [LINE_WIDTH-1:0]   line_sat;
  logic [LENGTH_WIDTH-1:0] len_sat;
  logic [KW-1:0]           id_kind;
  logic [3:0]              narrowed;
  logic                    is_alnum;

  // Effect of a byte seen from the idle mode.
  logic                    ib_emit;
  logic [KW-1:0]           ib_kind;
  logic [3:0]              ib_mode;
  logic                    ib_begin;
  logic [3:0]              ib_cand;
  logic                    ib_line_inc;

  logic                    a_v, b_v, do_idle;
  logic [KW-1:0]           a_kind, b_kind;
  logic [LINE_WIDTH-1:0]   a_line, b_line;
  logic [LENGTH_WIDTH-1:0] a_len, b_len;
  logic                    two, any, out_free, out_load;

  assign line_sat = (line_r == LINE_MAX) ? line_r : line_r + 1'b1;
  assign len_sat  = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;
  assign is_alnum = (item.cat == dl_pkg::C_ALPHA) || (item.cat == dl_pkg::C_DIGIT);
  assign narrowed = dl_pkg::kw_narrow(cand_r, item.ch, len_r < LEN_KW, len_r[2:0]);

  // The lowest numbered keyword that still matches at full length wins.
  always_comb begin
    id_kind = dl_pkg::K_ID;
    for (int k = 3; k >= 0; k--) begin
      if (cand_r[k] && (len_r == LENGTH_WIDTH'(dl_pkg::KW_LEN[k]))) begin
        id_kind = dl_pkg::K_KW0 + KW'(k);
      end
    end
  end

  always_comb begin
    ib_emit     = 1'b0;
    ib_kind     = dl_pkg::K_UNDEF;
    ib_mode     = dl_pkg::M_IDLE;
    ib_begin    = 1'b0;
    ib_cand     = 4'hF;
    ib_line_inc = 1'b0;
    unique case (item.cat)
      dl_pkg::C_PUNCT: begin
        ib_emit = 1'b1;
        ib_kind = item.punct;
      end
      dl_pkg::C_COLON: begin
        ib_mode  = dl_pkg::M_COLON;
        ib_begin = 1'b1;
      end
      dl_pkg::C_QUOTE: begin
        ib_mode  = dl_pkg::M_STR;
        ib_begin = 1'b1;
      end
      dl_pkg::C_HASH: begin
        ib_mode  = dl_pkg::M_HASH;
        ib_begin = 1'b1;
      end
      dl_pkg::C_NEWLINE: ib_line_inc = 1'b1;
      dl_pkg::C_SPACE: begin
      end
      dl_pkg::C_ALPHA: begin
        ib_mode  = dl_pkg::M_ID;
        ib_begin = 1'b1;
        ib_cand  = dl_pkg::kw_narrow(4'hF, item.ch, 1'b1, 3'd0);
      end
      default: ib_emit = 1'b1;
    endcase
  end

  // Token a flushes the pending token; token b belongs to the byte itself or is the end token.
  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    cand_nxt  = cand_r;
    ended_nxt = ended_r;
    a_v       = 1'b0;
    a_kind    = dl_pkg::K_ID;
    a_line    = start_r;
    a_len     = len_r;
    b_v       = 1'b0;
    b_kind    = dl_pkg::K_UNDEF;
    b_line    = line_r;
    b_len     = LEN_ONE;
    do_idle   = 1'b0;
    if (ended_r) begin
      // Everything after the end token is dropped.
    end else if (item.eoi) begin
      unique case (mode_r)
        dl_pkg::M_COLON: begin
          a_v    = 1'b1;
          a_kind = dl_pkg::K_COLON;
        end
        dl_pkg::M_ID: begin
          a_v    = 1'b1;
          a_kind = id_kind;
        end
        dl_pkg::M_STRQ: begin
          a_v    = 1'b1;
          a_kind = dl_pkg::K_STRING;
        end
        dl_pkg::M_HASH, dl_pkg::M_LINE: begin
          a_v    = 1'b1;
          a_kind = dl_pkg::K_COMMENT;
        end
        dl_pkg::M_STR, dl_pkg::M_BLOCK, dl_pkg::M_BLOCKBAR: begin
          a_v    = 1'b1;
          a_kind = dl_pkg::K_UNDEF;
        end
        default: a_v = 1'b0;
      endcase
      b_v       = 1'b1;
      b_kind    = dl_pkg::K_EOF;
      b_len     = '0;
      mode_nxt  = dl_pkg::M_IDLE;
      cand_nxt  = 4'hF;
      ended_nxt = 1'b1;
    end else begin
      unique case (mode_r)
        dl_pkg::M_COLON: begin
          a_v = 1'b1;
          if (item.dash) begin
            a_kind   = dl_pkg::K_COLONDASH;
            a_len    = LEN_TWO;
            mode_nxt = dl_pkg::M_IDLE;
            cand_nxt = 4'hF;
          end else begin
            a_kind  = dl_pkg::K_COLON;
            do_idle = 1'b1;
          end
        end
        dl_pkg::M_ID: begin
          if (is_alnum) begin
            cand_nxt = narrowed;
            len_nxt  = len_sat;
          end else begin
            a_v     = 1'b1;
            a_kind  = id_kind;
            do_idle = 1'b1;
          end
        end
        dl_pkg::M_STR: begin
          len_nxt = len_sat;
          if (item.cat == dl_pkg::C_NEWLINE) begin
            line_nxt = line_sat;
          end else if (item.cat == dl_pkg::C_QUOTE) begin
            mode_nxt = dl_pkg::M_STRQ;
          end
        end
        dl_pkg::M_STRQ: begin
          if (item.cat == dl_pkg::C_QUOTE) begin
            len_nxt  = len_sat;
            mode_nxt = dl_pkg::M_STR;
          end else begin
            a_v     = 1'b1;
            a_kind  = dl_pkg::K_STRING;
            do_idle = 1'b1;
          end
        end
        dl_pkg::M_HASH, dl_pkg::M_LINE: begin
          if (item.cat == dl_pkg::C_NEWLINE) begin
            a_v      = 1'b1;
            a_kind   = dl_pkg::K_COMMENT;
            line_nxt = line_sat;
            mode_nxt = dl_pkg::M_IDLE;
            cand_nxt = 4'hF;
          end else begin
            len_nxt  = len_sat;
            mode_nxt = ((mode_r == dl_pkg::M_HASH) && item.bar) ? dl_pkg::M_BLOCK
                                                                 : dl_pkg::M_LINE;
          end
        end
        dl_pkg::M_BLOCK, dl_pkg::M_BLOCKBAR: begin
          len_nxt = len_sat;
          if ((mode_r == dl_pkg::M_BLOCKBAR) && (item.cat == dl_pkg::C_HASH)) begin
            a_v      = 1'b1;
            a_kind   = dl_pkg::K_COMMENT;
            a_len    = len_sat;
            mode_nxt = dl_pkg::M_IDLE;
            cand_nxt = 4'hF;
          end else begin
            if (item.cat == dl_pkg::C_NEWLINE) begin
              line_nxt = line_sat;
            end
            mode_nxt = item.bar ? dl_pkg::M_BLOCKBAR : dl_pkg::M_BLOCK;
          end
        end
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        mode_nxt = ib_mode;
        cand_nxt = ib_cand;
        b_v      = ib_emit;
        b_kind   = ib_kind;
        if (ib_begin) begin
          start_nxt = line_r;
          len_nxt   = LEN_ONE;
        end
        if (ib_line_inc) begin
          line_nxt = line_sat;
        end
      end
    end
  end

  assign two      = a_v && b_v;
  assign any      = a_v || b_v;
  assign out_free = !out_valid_r || out_ready;

  // An item with two tokens holds the queue head until its second token is loaded into the output register.
  always_comb begin
    pop          = 1'b0;
    out_load     = 1'b0;
    phase_nxt    = phase_r;
    out_kind_nxt = out_kind_r;
    out_line_nxt = out_line_r;
    out_len_nxt  = out_len_r;
    out_last_nxt = out_last_r;
    if (item_valid) begin
      if (!any) begin
        pop = 1'b1;
      end else if (out_free) begin
        out_load = 1'b1;
        if (two && !phase_r) begin
          out_kind_nxt = a_kind;
          out_line_nxt = a_line;
          out_len_nxt  = a_len;
          out_last_nxt = 1'b0;
          phase_nxt    = 1'b1;
        end else if (two) begin
          out_kind_nxt = b_kind;
          out_line_nxt = b_line;
          out_len_nxt  = b_len;
          out_last_nxt = 1'b1;
          phase_nxt    = 1'b0;
          pop          = 1'b1;
        end else begin
          out_kind_nxt = a_v ? a_kind : b_kind;
          out_line_nxt = a_v ? a_line : b_line;
          out_len_nxt  = a_v ? a_len : b_len;
          out_last_nxt = 1'b1;
          pop          = 1'b1;
        end
      end
    end
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= dl_pkg::M_IDLE;
      line_r      <= LINE_WIDTH'(1);
      start_r     <= '0;
      len_r       <= '0;
      cand_r      <= 4'hF;
      ended_r     <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        mode_r  <= mode_nxt;
        line_r  <= line_nxt;
        start_r <= start_nxt;
        len_r   <= len_nxt;
        cand_r  <= cand_nxt;
        ended_r <= ended_nxt;
      end
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_line_r <= out_line_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_token_kind   = out_kind_r;
  assign out_token_line   = out_line_r;
  assign out_token_length = out_len_r;
  assign out_last_of_run  = out_last_r;

  a_split_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> item_valid)
    else $error("second token pending without a queued item");

  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |=> ended_r)
    else $error("end state left without reset");

  a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> !out_load)
    else $error("token produced after the end token");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line count wrapped to zero");

endmodule

// ===== design/datalog_lexer.sv =====
// Datalog lexer top level: front end, item queue and scanner back end.
// Takes one source byte per transaction (or an end marker) and returns Datalog tokens with
// their kind, start line and length, last_of_run marking the final token of each byte. A
// byte that produces no token or one token is taken every clock cycle unless output stalls;
// a byte that first flushes a pending token and then yields its own, or the end marker
// with a pending token, holds the scanner until both tokens have left through the one
// output register. A four-entry queue between the classifier and the scanner absorbs
// these holds and output stalls. The first token of a byte is presented only after the
// byte has passed through the queue and then the output register.
module datalog_lexer #(
  parameter int LINE_WIDTH   = dl_pkg::LINE_WIDTH_DEF,
  parameter int LENGTH_WIDTH = dl_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_end_of_input,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dl_pkg::KIND_WIDTH-1:0] out_token_kind,
  output logic [LINE_WIDTH-1:0]         out_token_line,
  output logic [LENGTH_WIDTH-1:0]       out_token_length,
  output logic                          out_last_of_run
);

  logic          q_full, q_push, q_pop, q_not_empty;
  dl_pkg::item_t q_wr_item, q_rd_item;

  dl_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_wr_item)
  );

  dl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_item   (q_wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .rd_item   (q_rd_item),
    .not_empty (q_not_empty)
  );

  dl_back #(
    .LINE_WIDTH   (LINE_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item             (q_rd_item),
    .item_valid       (q_not_empty),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
